[rtl/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg - shared types and constants for the character LCD sequencer
// Opcodes, register indexes, sequence step numbers and the control/status
// structs passed between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

   typedef enum logic [2:0] {
      OP_INIT  = 3'd0,
      OP_CMD   = 3'd1,
      OP_CHAR  = 3'd2,
      OP_GOTO  = 3'd3,
      OP_CLEAR = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      REG_FUNCTION_SET = 2'd0,
      REG_DISPLAY_CTRL = 2'd1,
      REG_ENTRY_MODE   = 2'd2
   } reg_idx_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   localparam int unsigned STEP_W = 5;
   localparam int unsigned ADDR_W = 4;

   // step numbers within a request
   localparam logic [STEP_W-1:0] INIT_FOUR_BIT_STEP = 5'd7;
   localparam logic [STEP_W-1:0] INIT_BYTE_STEP     = 5'd9;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP     = 5'd24;
   localparam logic [STEP_W-1:0] CHAR_LAST_STEP     = 5'd4;
   localparam logic [STEP_W-1:0] CMD_LAST_STEP      = 5'd3;

   localparam logic [7:0] CMD_CLEAR        = 8'h01;
   localparam logic [3:0] INIT_WAKE_NIBBLE = 4'h3;
   localparam logic [3:0] INIT_4BIT_NIBBLE = 4'h2;

   localparam logic [7:0] FUNCTION_SET_RESET = 8'h28;
   localparam logic [7:0] DISPLAY_CTRL_RESET = 8'h0C;
   localparam logic [7:0] ENTRY_MODE_RESET   = 8'h06;

   localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

   typedef struct packed {
      logic              capture;
      logic              load;
      logic [STEP_W-1:0] step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_op_ok;
      logic out_free;
      logic is_final;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/clcd_if.sv]
// ----------------------------------------------------------------------------
// clcd_if - request and pin-state channels
// Valid/ready channels carrying one request word and one pin-state word.
// ----------------------------------------------------------------------------
`default_nettype none

interface clcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] data_byte;
   logic [7:0] column;
   logic [1:0] row;

   modport source (output valid, output opcode, output data_byte, output column,
                   output row, input ready);
   modport sink   (input valid, input opcode, input data_byte, input column,
                   input row, output ready);
endinterface

interface clcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] data_nibble;
   logic       enable_level;
   logic       register_select;
   logic       read_write;
   logic [1:0] hold_ms;
   logic       last;

   modport source (output valid, output data_nibble, output enable_level,
                   output register_select, output read_write, output hold_ms,
                   output last, input ready);
   modport sink   (input valid, input data_nibble, input enable_level,
                   input register_select, input read_write, input hold_ms,
                   input last, output ready);
endinterface

`default_nettype wire

[rtl/char_lcd_4bit_write_sequencer.sv]
// ----------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer - HD44780-style 4-bit write sequencer
// Turns init / command / character / go-to / clear requests into timed
// pin-state words for a character LCD on a 4-bit bus.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake        | word
//  ----------+-----+------------------+-------------------------------------
//  req_ch    | in  | valid/ready      | opcode, data_byte, column, row
//  rsp_ch    | out | valid/ready      | nibble, E, RS, RW, hold_ms, last
//  csr_*     | in  | APB, pready = 1  | function set, display ctrl, entry mode
//
//  Output: one pin-state word per cycle when the sink keeps up; a request
//  gives 4 (command, go-to, clear), 5 (character) or 25 (init) words,
//  set by the step counter in the controller.
//  Reset: synchronous, active high; control registers return to 0x28,
//  0x0C and 0x06. Unused opcodes are taken and give no word.
//  Stalls: the output register holds a word until taken; the next step is
//  built in the same cycle the sink takes the current one. A new request
//  is taken once the previous one's last word is in the output register.
//
`default_nettype none

module char_lcd_4bit_write_sequencer (
   input  wire logic                        clock,
   input  wire logic                        reset,
   clcd_req_if.sink                         req_ch,
   clcd_rsp_if.source                       rsp_ch,
   input  wire logic                        csr_psel,
   input  wire logic                        csr_penable,
   input  wire logic                        csr_pwrite,
   input  wire logic [clcd_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                 csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   clcd_pkg::ctrl_cmd_type  cmd;
   clcd_pkg::dp_status_type status;

   assign csr_pready = 1'b1;

   // controller: idle/emit machine and step counter
   clcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: registers, captured request, pin-state build, output word
   clcd_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .req_opcode          (req_ch.opcode),
      .req_data_byte       (req_ch.data_byte),
      .req_column          (req_ch.column),
      .req_row             (req_ch.row),
      .cmd                 (cmd),
      .status              (status),
      .rsp_ready           (rsp_ch.ready),
      .rsp_valid           (rsp_ch.valid),
      .rsp_data_nibble     (rsp_ch.data_nibble),
      .rsp_enable_level    (rsp_ch.enable_level),
      .rsp_register_select (rsp_ch.register_select),
      .rsp_read_write      (rsp_ch.read_write),
      .rsp_hold_ms         (rsp_ch.hold_ms),
      .rsp_last            (rsp_ch.last)
   );

endmodule

`default_nettype wire

[rtl/clcd_ctrl.sv]
// ----------------------------------------------------------------------------
// clcd_ctrl - sequencing controller
// Takes a request, then walks the step counter one pin state at a time
// whenever the output register can take a word.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire clcd_pkg::dp_status_type status,
   output clcd_pkg::ctrl_cmd_type     cmd
);

   clcd_pkg::state_type state_ff, state_in;
   logic [clcd_pkg::STEP_W-1:0] step_ff, step_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clcd_pkg::ST_IDLE: begin
            if (req_valid && status.req_op_ok) state_in = clcd_pkg::ST_EMIT;
         end
         clcd_pkg::ST_EMIT: begin
            if (status.out_free && status.is_final) state_in = clcd_pkg::ST_IDLE;
         end
         default: state_in = clcd_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.step    = step_ff;
      step_in     = step_ff;
      unique case (state_ff)
         clcd_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            step_in     = '0;
         end
         clcd_pkg::ST_EMIT: begin
            cmd.load = status.out_free;
            if (status.out_free) begin
               step_in = status.is_final ? '0 : step_ff + 1'b1;
            end
         end
         default: step_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clcd_pkg::ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   a_idle_step_zero: assert property (@(posedge clock) disable iff (reset)
      state_ff == clcd_pkg::ST_IDLE |-> step_ff == '0)
      else $error("step counter not cleared while idle");

   a_load_only_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> state_ff == clcd_pkg::ST_EMIT)
      else $error("pin state loaded outside a sequence");

   a_final_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && status.is_final) |=> state_ff == clcd_pkg::ST_IDLE)
      else $error("sequence ran past its final step");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_ff <= clcd_pkg::INIT_LAST_STEP)
      else $error("step counter out of range");

endmodule

`default_nettype wire

[rtl/clcd_dp.sv]
// ----------------------------------------------------------------------------
// clcd_dp - sequencer datapath
// Holds the control registers and the captured request, builds the pin
// state for each step and keeps the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clcd_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [clcd_pkg::ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   input  wire logic [2:0]                 req_opcode,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic [7:0]                 req_column,
   input  wire logic [1:0]                 req_row,
   input  wire clcd_pkg::ctrl_cmd_type     cmd,
   output clcd_pkg::dp_status_type         status,
   input  wire logic                       rsp_ready,
   output logic                            rsp_valid,
   output logic [3:0]                      rsp_data_nibble,
   output logic                            rsp_enable_level,
   output logic                            rsp_register_select,
   output logic                            rsp_read_write,
   output logic [1:0]                      rsp_hold_ms,
   output logic                            rsp_last
);

   logic [7:0] function_set_ff, display_ctrl_ff, entry_mode_ff;
   clcd_pkg::reg_idx_type reg_idx;
   logic       csr_write;

   clcd_pkg::op_type op_ff;
   logic [7:0]       byte_ff, byte_in;

   logic             valid_ff;
   logic [3:0]       nibble_ff, nibble_in;
   logic             enable_ff, enable_in;
   logic             select_ff, select_in;
   logic [1:0]       hold_ff, hold_in;
   logic             last_ff;

   logic [clcd_pkg::STEP_W-1:0] init_t;
   logic [7:0]                  init_word;
   logic                        is_final;

   // ---- control registers
   assign reg_idx   = clcd_pkg::reg_idx_type'(csr_paddr[3:2]);
   assign csr_write = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         function_set_ff <= clcd_pkg::FUNCTION_SET_RESET;
         display_ctrl_ff <= clcd_pkg::DISPLAY_CTRL_RESET;
         entry_mode_ff   <= clcd_pkg::ENTRY_MODE_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            clcd_pkg::REG_FUNCTION_SET: function_set_ff <= csr_pwdata[7:0];
            clcd_pkg::REG_DISPLAY_CTRL: display_ctrl_ff <= csr_pwdata[7:0];
            clcd_pkg::REG_ENTRY_MODE:   entry_mode_ff   <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         clcd_pkg::REG_FUNCTION_SET: csr_prdata = {24'd0, function_set_ff};
         clcd_pkg::REG_DISPLAY_CTRL: csr_prdata = {24'd0, display_ctrl_ff};
         clcd_pkg::REG_ENTRY_MODE:   csr_prdata = {24'd0, entry_mode_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // ---- request capture; go-to address and clear byte resolved here
   always_comb begin
      unique case (clcd_pkg::op_type'(req_opcode))
         clcd_pkg::OP_GOTO:  byte_in = clcd_pkg::ROW_BASE[req_row] + req_column;
         clcd_pkg::OP_CLEAR: byte_in = clcd_pkg::CMD_CLEAR;
         default:            byte_in = req_data_byte;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= clcd_pkg::op_type'(req_opcode);
         byte_ff <= byte_in;
      end
   end

   // ---- pin state for the current step
   assign init_t = cmd.step - clcd_pkg::INIT_BYTE_STEP;

   always_comb begin
      unique case (init_t[3:2])
         2'd0:    init_word = function_set_ff;
         2'd1:    init_word = display_ctrl_ff;
         2'd2:    init_word = entry_mode_ff;
         default: init_word = clcd_pkg::CMD_CLEAR;
      endcase
   end

   always_comb begin
      nibble_in = byte_ff[7:4];
      enable_in = 1'b0;
      select_in = 1'b0;
      hold_in   = 2'd1;
      is_final  = 1'b0;
      unique case (op_ff)
         clcd_pkg::OP_INIT: begin
            is_final = (cmd.step == clcd_pkg::INIT_LAST_STEP);
            if (cmd.step == '0) begin
               nibble_in = '0;
               hold_in   = 2'd0;
            end else if (cmd.step < clcd_pkg::INIT_BYTE_STEP) begin
               nibble_in = (cmd.step < clcd_pkg::INIT_FOUR_BIT_STEP) ?
                           clcd_pkg::INIT_WAKE_NIBBLE : clcd_pkg::INIT_4BIT_NIBBLE;
               enable_in = cmd.step[0];
            end else begin
               nibble_in = init_t[1] ? init_word[3:0] : init_word[7:4];
               enable_in = !init_t[0];
            end
         end
         clcd_pkg::OP_CHAR: begin
            is_final = (cmd.step == clcd_pkg::CHAR_LAST_STEP);
            if (is_final) begin
               // trailing state: RS back low, bus left on the low nibble
               nibble_in = byte_ff[3:0];
               hold_in   = 2'd0;
            end else begin
               nibble_in = cmd.step[1] ? byte_ff[3:0] : byte_ff[7:4];
               enable_in = !cmd.step[0];
               select_in = 1'b1;
            end
         end
         default: begin
            is_final  = (cmd.step == clcd_pkg::CMD_LAST_STEP);
            nibble_in = cmd.step[1] ? byte_ff[3:0] : byte_ff[7:4];
            enable_in = !cmd.step[0];
            if (is_final && op_ff == clcd_pkg::OP_CLEAR) hold_in = 2'd2;
         end
      endcase
   end

   // ---- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nibble_ff <= nibble_in;
         enable_ff <= enable_in;
         select_ff <= select_in;
         hold_ff   <= hold_in;
         last_ff   <= is_final;
      end
   end

   assign status.req_op_ok = (req_opcode <= 3'(clcd_pkg::OP_CLEAR));
   assign status.out_free  = !valid_ff || rsp_ready;
   assign status.is_final  = is_final;

   assign rsp_valid           = valid_ff;
   assign rsp_data_nibble     = nibble_ff;
   assign rsp_enable_level    = enable_ff;
   assign rsp_register_select = select_ff;
   assign rsp_read_write      = 1'b0;
   assign rsp_hold_ms         = hold_ff;
   assign rsp_last            = last_ff;

endmodule

`default_nettype wire
